FILE: rtl/core/vertical_box_blur_rgba_unit_macros.svh
// Assertion macros for the vertical box blur unit.
// Used by the top level only; no other dependencies.
`ifndef VERTICAL_BOX_BLUR_RGBA_UNIT_MACROS_SVH
`define VERTICAL_BOX_BLUR_RGBA_UNIT_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define VBBR_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vbbr same-cycle check failed");

// Next-cycle implication, checked while out of reset.
`define VBBR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vbbr next-cycle check failed");

`endif

FILE: rtl/core/vbbr_pkg.sv
// Shared types, constants and the reciprocal table of the vertical box blur unit.
// No dependencies.
package vbbr_pkg;

   localparam int MAX_RADIUS_DEF = 31;
   localparam int RADIUS_W       = 5;
   localparam int PIX_W          = 32;
   localparam int CHAN_W         = 8;
   localparam int NUM_CHAN       = 4;
   localparam int SUM_W          = 14;
   localparam int K_W            = RADIUS_W + 1;
   localparam int FRAC_W         = 24;
   localparam int RECIP_W        = FRAC_W + 1;
   localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SLIDE,
      ST_SCALE
   } state_type;

   // Sequencer to datapath
   typedef struct packed {
      logic load_px;
      logic first;
      logic slide;
      logic emit;
      logic done;
   } ctl_type;

   // Sequencer status seen by the top level
   typedef struct packed {
      logic busy;
      logic col_start;
   } status_type;

   // floor(2^24 / (2r+1)) for every 5-bit radius
   function automatic logic [RECIP_W-1:0] recip_of(input logic [RADIUS_W-1:0] r);
      logic [RECIP_W-1:0] v;
      case (r)
         5'd0:    v = 25'd16777216;
         5'd1:    v = 25'd5592405;
         5'd2:    v = 25'd3355443;
         5'd3:    v = 25'd2396745;
         5'd4:    v = 25'd1864135;
         5'd5:    v = 25'd1525201;
         5'd6:    v = 25'd1290555;
         5'd7:    v = 25'd1118481;
         5'd8:    v = 25'd986895;
         5'd9:    v = 25'd883011;
         5'd10:   v = 25'd798915;
         5'd11:   v = 25'd729444;
         5'd12:   v = 25'd671088;
         5'd13:   v = 25'd621378;
         5'd14:   v = 25'd578524;
         5'd15:   v = 25'd541200;
         5'd16:   v = 25'd508400;
         5'd17:   v = 25'd479349;
         5'd18:   v = 25'd453438;
         5'd19:   v = 25'd430185;
         5'd20:   v = 25'd409200;
         5'd21:   v = 25'd390167;
         5'd22:   v = 25'd372827;
         5'd23:   v = 25'd356962;
         5'd24:   v = 25'd342392;
         5'd25:   v = 25'd328965;
         5'd26:   v = 25'd316551;
         5'd27:   v = 25'd305040;
         5'd28:   v = 25'd294337;
         5'd29:   v = 25'd284359;
         5'd30:   v = 25'd275036;
         5'd31:   v = 25'd266305;
         default: v = 25'd16777216;
      endcase
      return v;
   endfunction

endpackage

FILE: rtl/core/vertical_box_blur_rgba_unit.sv
// Channel  Ports                                   Direction
// req      req_valid req_stall req_pixel_in         in
//          req_column_end
// rsp      rsp_valid rsp_stall rsp_pixel_out        out
//          rsp_column_done
// csr      csr_wr_en csr_wr_data                   in
//
// An input pixel is accepted, its window row is read and the sums are updated;
// a pixel that yields an output is then scaled into the result register.
// The bottom pixel then flushes r rows, each with its own window read and sum
// update and, for a row that yields an output, a scale step.
// Synchronous active-high reset sets the radius to 1 and starts a new column.
// A stalled result holds the scale step; input stays stalled until a pixel is done.
//
// Top level of the vertical box blur; uses vbbr_pkg, vbbr_ctrl, vbbr_datapath,
// vbbr_window_mem and the assertion macro header.
`include "vertical_box_blur_rgba_unit_macros.svh"

module vertical_box_blur_rgba_unit #(
   parameter int MAX_RADIUS = vbbr_pkg::MAX_RADIUS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [vbbr_pkg::PIX_W-1:0]    req_pixel_in,
   input  logic                          req_column_end,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [vbbr_pkg::PIX_W-1:0]    rsp_pixel_out,
   output logic                          rsp_column_done,
   input  logic                          csr_wr_en,
   input  logic [vbbr_pkg::RADIUS_W-1:0] csr_wr_data
);
   import vbbr_pkg::*;

   localparam int WIN_DEPTH = 2 * MAX_RADIUS + 2;
   localparam int ADDR_W    = $clog2(WIN_DEPTH);

   ctl_type             ctl;
   status_type          status;
   logic                out_free;
   logic                mem_wr_en;
   logic [ADDR_W-1:0]   mem_wr_addr;
   logic                mem_rd_en;
   logic [ADDR_W-1:0]   mem_rd_addr;
   logic [PIX_W-1:0]    rd_data;
   logic [K_W-1:0]      k_val;
   logic [RECIP_W-1:0]  recip;

   vbbr_ctrl #(
      .MAX_RADIUS (MAX_RADIUS)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_column_end (req_column_end),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .out_free       (out_free),
      .ctl            (ctl),
      .status         (status),
      .mem_wr_en      (mem_wr_en),
      .mem_wr_addr    (mem_wr_addr),
      .mem_rd_en      (mem_rd_en),
      .mem_rd_addr    (mem_rd_addr),
      .k_val          (k_val),
      .recip          (recip)
   );

   vbbr_window_mem #(
      .DEPTH (WIN_DEPTH)
   ) u_window_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (req_pixel_in),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (rd_data)
   );

   vbbr_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .k_val           (k_val),
      .recip           (recip),
      .req_pixel_in    (req_pixel_in),
      .rd_data         (rd_data),
      .out_free        (out_free),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_out   (rsp_pixel_out),
      .rsp_column_done (rsp_column_done)
   );

   // A transaction on the input keeps the sequencer busy for the next cycle
   `VBBR_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, status.busy)
   // The result register is loaded only when it is free
   `VBBR_ASSERT_IMPL(a_emit_into_free, clock, reset, ctl.emit, !rsp_valid || !rsp_stall)
   // The flagged last output ends the column and returns to idle
   `VBBR_ASSERT_NEXT(a_done_clears, clock, reset, ctl.emit && ctl.done, !status.busy && status.col_start)

endmodule

FILE: rtl/core/vbbr_window_mem.sv
// Row window memory: one write port, one read port, registered read data.
// Depends on vbbr_pkg for the pixel width.
module vbbr_window_mem #(
   parameter int  DEPTH  = 2 * vbbr_pkg::MAX_RADIUS_DEF + 2,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [ADDR_W-1:0]          wr_addr,
   input  logic [vbbr_pkg::PIX_W-1:0] wr_data,
   input  logic                       rd_en,
   input  logic [ADDR_W-1:0]          rd_addr,
   output logic [vbbr_pkg::PIX_W-1:0] rd_data
);
   import vbbr_pkg::*;

   logic [PIX_W-1:0] mem [DEPTH];
   logic [PIX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/vbbr_ctrl.sv
// Sequencer: radius register, row counters, window addressing and flush steps.
// Depends on vbbr_pkg for the state enum, control structs and reciprocal table.
module vbbr_ctrl #(
   parameter int  MAX_RADIUS = vbbr_pkg::MAX_RADIUS_DEF,
   localparam int WIN_DEPTH  = 2 * MAX_RADIUS + 2,
   localparam int ADDR_W     = $clog2(WIN_DEPTH),
   localparam int CNT_W      = $clog2(WIN_DEPTH + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_column_end,
   input  logic                          csr_wr_en,
   input  logic [vbbr_pkg::RADIUS_W-1:0] csr_wr_data,
   input  logic                          out_free,
   output vbbr_pkg::ctl_type             ctl,
   output vbbr_pkg::status_type          status,
   output logic                          mem_wr_en,
   output logic [ADDR_W-1:0]             mem_wr_addr,
   output logic                          mem_rd_en,
   output logic [ADDR_W-1:0]             mem_rd_addr,
   output logic [vbbr_pkg::K_W-1:0]      k_val,
   output logic [vbbr_pkg::RECIP_W-1:0]  recip
);
   import vbbr_pkg::*;

   state_type            state_ff, state_in;
   logic [RADIUS_W-1:0]  radius_ff, radius_in;
   logic [RECIP_W-1:0]   recip_ff, recip_in;
   logic [CNT_W-1:0]     rows_ff, rows_in;
   logic [ADDR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0]     m_ff, m_in;
   logic [ADDR_W-1:0]    lv_ptr_ff, lv_ptr_in;
   logic [RADIUS_W-1:0]  step_ff, step_in;
   logic                 last_ff, last_in;

   logic                 accept;
   logic                 emit_needed;
   logic                 step_end;
   logic                 more_steps;
   logic [RADIUS_W-1:0]  r_sat;
   logic [ADDR_W-1:0]    lv_start;

   assign k_val  = {radius_ff, 1'b1};
   assign recip  = recip_ff;
   assign accept = (state_ff == ST_IDLE) && req_valid;

   assign emit_needed = int'(m_ff) >= int'(radius_ff);
   assign step_end    = ((state_ff == ST_SLIDE) && !emit_needed)
                        || ((state_ff == ST_SCALE) && out_free);
   assign more_steps  = last_ff && (step_ff < radius_ff);

   always_comb begin
      if (int'(csr_wr_data) > MAX_RADIUS) begin
         r_sat = RADIUS_W'(MAX_RADIUS);
      end else begin
         r_sat = csr_wr_data;
      end
   end

   // Address of row n-k for the row being accepted, modulo the window depth
   always_comb begin
      if (int'(wr_ptr_ff) >= int'(k_val)) begin
         lv_start = ADDR_W'(int'(wr_ptr_ff) - int'(k_val));
      end else begin
         lv_start = ADDR_W'(int'(wr_ptr_ff) + WIN_DEPTH - int'(k_val));
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_READ;
            end
         end
         ST_READ:  state_in = ST_SLIDE;
         ST_SLIDE: begin
            if (emit_needed) begin
               state_in = ST_SCALE;
            end else if (more_steps) begin
               state_in = ST_READ;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SCALE: begin
            if (out_free) begin
               state_in = more_steps ? ST_READ : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs and datapath registers
   always_comb begin
      radius_in = radius_ff;
      recip_in  = recip_ff;
      rows_in   = rows_ff;
      wr_ptr_in = wr_ptr_ff;
      m_in      = m_ff;
      lv_ptr_in = lv_ptr_ff;
      step_in   = step_ff;
      last_in   = last_ff;

      if (csr_wr_en) begin
         radius_in = r_sat;
         recip_in  = recip_of(r_sat);
         rows_in   = '0;
         wr_ptr_in = '0;
      end else if (accept) begin
         last_in   = req_column_end;
         m_in      = rows_ff;
         lv_ptr_in = lv_start;
         step_in   = '0;
         rows_in   = (rows_ff == CNT_W'(WIN_DEPTH)) ? rows_ff : rows_ff + 1'b1;
         wr_ptr_in = (wr_ptr_ff == ADDR_W'(WIN_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end else if (step_end) begin
         if (more_steps) begin
            // advance to the next repeated bottom row
            step_in   = step_ff + 1'b1;
            m_in      = (m_ff == CNT_W'(WIN_DEPTH)) ? m_ff : m_ff + 1'b1;
            lv_ptr_in = (lv_ptr_ff == ADDR_W'(WIN_DEPTH - 1)) ? '0 : lv_ptr_ff + 1'b1;
         end else if (last_ff) begin
            rows_in   = '0;
            wr_ptr_in = '0;
         end
      end
   end

   always_comb begin
      req_stall   = (state_ff != ST_IDLE);
      mem_wr_en   = accept;
      mem_wr_addr = wr_ptr_ff;
      mem_rd_en   = (state_ff == ST_READ);
      // rows above the column repeat row 0, which sits at address 0
      mem_rd_addr = (int'(m_ff) <= int'(k_val)) ? '0 : lv_ptr_ff;

      ctl.load_px = accept;
      ctl.first   = (m_ff == '0);
      ctl.slide   = (state_ff == ST_SLIDE);
      ctl.emit    = (state_ff == ST_SCALE) && out_free;
      ctl.done    = last_ff && (step_ff == radius_ff);

      status.busy      = (state_ff != ST_IDLE);
      status.col_start = (rows_ff == '0) && (wr_ptr_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         radius_ff <= RADIUS_RESET;
         recip_ff  <= recip_of(RADIUS_RESET);
         rows_ff   <= '0;
         wr_ptr_ff <= '0;
         m_ff      <= '0;
         lv_ptr_ff <= '0;
         step_ff   <= '0;
         last_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         radius_ff <= radius_in;
         recip_ff  <= recip_in;
         rows_ff   <= rows_in;
         wr_ptr_ff <= wr_ptr_in;
         m_ff      <= m_in;
         lv_ptr_ff <= lv_ptr_in;
         step_ff   <= step_in;
         last_ff   <= last_in;
      end
   end

endmodule

FILE: rtl/core/vbbr_datapath.sv
// Channel sums, reciprocal scaling and the result register.
// Depends on vbbr_pkg for widths and the control struct.
module vbbr_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  vbbr_pkg::ctl_type            ctl,
   input  logic [vbbr_pkg::K_W-1:0]     k_val,
   input  logic [vbbr_pkg::RECIP_W-1:0] recip,
   input  logic [vbbr_pkg::PIX_W-1:0]   req_pixel_in,
   input  logic [vbbr_pkg::PIX_W-1:0]   rd_data,
   output logic                         out_free,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [vbbr_pkg::PIX_W-1:0]   rsp_pixel_out,
   output logic                         rsp_column_done
);
   import vbbr_pkg::*;

   localparam int PROD_W = SUM_W + RECIP_W;

   logic [PIX_W-1:0]  px_ff, px_in;
   logic [SUM_W-1:0]  sum_ff [NUM_CHAN];
   logic [SUM_W-1:0]  sum_in [NUM_CHAN];
   logic              valid_ff, valid_in;
   logic [PIX_W-1:0]  pix_ff, pix_in;
   logic              done_ff, done_in;
   logic [PROD_W-1:0] prod [NUM_CHAN];

   assign out_free = !valid_ff || !rsp_stall;
   assign px_in    = ctl.load_px ? req_pixel_in : px_ff;

   always_comb begin
      for (int c = 0; c < NUM_CHAN; c++) begin
         sum_in[c] = sum_ff[c];
         if (ctl.slide) begin
            if (ctl.first) begin
               sum_in[c] = SUM_W'(k_val) * SUM_W'(px_ff[c*CHAN_W +: CHAN_W]);
            end else begin
               sum_in[c] = SUM_W'(sum_ff[c] + SUM_W'(px_ff[c*CHAN_W +: CHAN_W])
                                  - SUM_W'(rd_data[c*CHAN_W +: CHAN_W]));
            end
         end
      end
   end

   always_comb begin
      pix_in = pix_ff;
      for (int c = 0; c < NUM_CHAN; c++) begin
         prod[c] = PROD_W'(sum_ff[c]) * PROD_W'(recip);
         if (ctl.emit) begin
            pix_in[c*CHAN_W +: CHAN_W] = prod[c][FRAC_W +: CHAN_W];
         end
      end
      done_in  = ctl.emit ? ctl.done : done_ff;
      // hold while stalled, drop once taken
      valid_in = ctl.emit || (valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      px_ff   <= px_in;
      pix_ff  <= pix_in;
      done_ff <= done_in;
      for (int c = 0; c < NUM_CHAN; c++) begin
         sum_ff[c] <= sum_in[c];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_pixel_out   = pix_ff;
   assign rsp_column_done = done_ff;

endmodule
